[hw/rtl/lkvc_pkg.sv]
// Shared types and constants of the LRU key-value cache.
package lkvc_pkg;

   // Field widths of the request and result items
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CAP_W      = 5;

   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;
   localparam logic [CAP_W-1:0]      CAP_RESET     = 5'd16;

   // Read value returned on a miss
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   // Request operation codes
   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_put;
      logic rsp_free;
   } ctrl_status_type;

endpackage

[hw/rtl/lkvc_req_if.sv]
// Request channel: operation, key and value with a valid/ready handshake.
interface lkvc_req_if import lkvc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic signed [KEY_W-1:0]   key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

[hw/rtl/lkvc_rsp_if.sv]
// Result channel: hit flag and read value with a valid/ready handshake.
interface lkvc_rsp_if import lkvc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

[hw/rtl/lkvc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/lkvc_ctrl.sv]
// Controller state machine: sequences capture, lookup and commit of each item.
module lkvc_ctrl import lkvc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      can_commit;

   // A get commits only when the result register is free
   assign can_commit = status.is_put || status.rsp_free;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (can_commit) begin
               cmd.commit = 1'b1;
               req_ready  = !reset;
               if (req_valid && !reset) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_LOOKUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[hw/rtl/lkvc_datapath.sv]
// Datapath: tag, age and valid stores, data RAM, lookup registers, result and CSR.
module lkvc_datapath import lkvc_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   output ctrl_status_type           status,
   input  logic                      req_cmd,
   input  logic signed [KEY_W-1:0]   req_key,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int AGE_W = IDX_W;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
   localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_ENTRIES);

   // Captured item
   logic                      op_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic signed [VALUE_W-1:0] val_ff;

   // Stores
   logic                      valid_ff [MAX_ENTRIES];
   logic                      valid_in [MAX_ENTRIES];
   logic [AGE_W-1:0]          age_ff   [MAX_ENTRIES];
   logic [AGE_W-1:0]          age_in   [MAX_ENTRIES];
   logic signed [KEY_W-1:0]   tag_ff   [MAX_ENTRIES];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CAP_W-1:0]          cap_ff;

   // Lookup results
   logic                      hit_ff;
   logic [IDX_W-1:0]          hit_idx_ff;
   logic [AGE_W-1:0]          hit_age_ff;
   logic                      full_ff;
   logic [IDX_W-1:0]          victim_idx_ff;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff;
   logic [VALUE_W-1:0]        rsp_data_ff;

   logic                      match_any;
   logic [IDX_W-1:0]          match_idx;
   logic [AGE_W-1:0]          match_age;
   logic [IDX_W-1:0]          victim_idx;
   logic [AGE_W-1:0]          last_age;
   logic [EXT_W-1:0]          cap_ext, eff_cap, count_ext;
   logic                      is_put, do_fill, do_touch, do_evict;
   logic [IDX_W-1:0]          fill_idx, touch_idx, wr_idx;
   logic [AGE_W-1:0]          touch_age;
   logic [VALUE_W-1:0]        ram_rd_data;
   logic                      csr_write;

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_cmd;
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   // Clamp the capacity register to 1..MAX_ENTRIES
   always_comb begin
      cap_ext   = EXT_W'(cap_ff);
      count_ext = EXT_W'(count_ff);
      if (cap_ext == '0) begin
         eff_cap = EXT_W'(1);
      end else if (cap_ext > MAX_EXT) begin
         eff_cap = MAX_EXT;
      end else begin
         eff_cap = cap_ext;
      end
   end

   // Compare all tags and find the oldest valid entry
   assign last_age = AGE_W'(count_ff - CNT_W'(1));

   always_comb begin
      match_any  = 1'b0;
      match_idx  = '0;
      match_age  = '0;
      victim_idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (valid_ff[i] && tag_ff[i] == key_ff) begin
            match_any = 1'b1;
            match_idx = match_idx | IDX_W'(i);
            match_age = match_age | age_ff[i];
         end
         if (valid_ff[i] && age_ff[i] == last_age) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
      end
   end

   // Hold the lookup outcome for the update cycle
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff        <= match_any;
         hit_idx_ff    <= match_idx;
         hit_age_ff    <= match_age;
         full_ff       <= count_ext >= eff_cap;
         victim_idx_ff <= victim_idx;
      end
   end

   // Choose the slot that the update touches
   assign is_put    = (op_ff == OP_PUT);
   assign do_fill   = cmd.commit && is_put && !hit_ff && !full_ff;
   assign do_evict  = cmd.commit && is_put && !hit_ff && full_ff;
   assign do_touch  = (cmd.commit && hit_ff) || do_evict;
   assign fill_idx  = count_ff[IDX_W-1:0];
   assign touch_idx = hit_ff ? hit_idx_ff : victim_idx_ff;
   assign touch_age = hit_ff ? hit_age_ff : last_age;
   assign wr_idx    = hit_ff ? hit_idx_ff : (full_ff ? victim_idx_ff : fill_idx);

   // Age, valid and count updates
   always_comb begin
      count_in = do_fill ? count_ff + CNT_W'(1) : count_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         age_in[i]   = age_ff[i];
         if (do_fill) begin
            if (fill_idx == IDX_W'(i)) begin
               valid_in[i] = 1'b1;
               age_in[i]   = '0;
            end else if (valid_ff[i]) begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end else if (do_touch) begin
            if (touch_idx == IDX_W'(i)) begin
               age_in[i] = '0;
            end else if (valid_ff[i] && age_ff[i] < touch_age) begin
               age_in[i] = age_ff[i] + AGE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            age_ff[i]   <= age_in[i];
         end
      end
   end

   // Write the new key on fill or eviction
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if ((do_fill || do_evict) && wr_idx == IDX_W'(i)) begin
            tag_ff[i] <= key_ff;
         end
      end
   end

   // Value store: read during lookup, write on commit of a put
   lkvc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && is_put),
      .wr_addr (wr_idx),
      .wr_data (val_ff),
      .rd_en   (cmd.lookup),
      .rd_addr (match_idx),
      .rd_data (ram_rd_data)
   );

   // Load the result of a get, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit && !is_put) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !is_put) begin
         rsp_hit_ff  <= hit_ff;
         rsp_data_ff <= hit_ff ? ram_rd_data : MISS_VALUE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_data_ff;

   assign status.is_put   = is_put;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // Capacity register
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write && paddr == ADDR_CAPACITY) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_CAPACITY) begin
         prdata[CAP_W-1:0] = cap_ff;
      end
   end

   assign pready = 1'b1;
endmodule

[hw/rtl/lru_key_value_cache.sv]
// Top level of the fully associative key-value cache with LRU replacement.
//
//   channel  | direction | handshake       | payload
//   ---------+-----------+-----------------+---------------------------------
//   req_chan | in        | valid / ready   | cmd, key, value
//   rsp_chan | out       | valid / ready   | hit, read_value (one per get)
//   csr      | in / out  | psel / penable  | capacity_in_use at address 0
//
// An item passes a lookup state, which compares the key against every stored
// tag, and an update state, which updates the age, tag and value stores. A new
// item can be taken in the update cycle of the previous one, while that one commits.
// Reset clears valid bits, ages and count at once; no clearing pass.
// A get holds in its update cycle while the previous result has not been taken.
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lkvc_req_if.sink              req_chan,
   lkvc_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   lkvc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .status         (ctrl_status),
      .req_cmd        (req_chan.cmd),
      .req_key        (req_chan.key),
      .req_value      (req_chan.value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_hit        (rsp_chan.hit),
      .rsp_read_value (rsp_chan.read_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );
endmodule

[hw/rtl/lkvc_checker.sv]
// Port-level checker of the key-value cache and its bind to the top level.
module lkvc_checker import lkvc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [VALUE_W-1:0] rsp_read_value
);
   // A miss always reads as all ones
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == MISS_VALUE)
      else $error("miss result without all-ones read value");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("result changed while stalled");

   // No item is taken in the cycle after an accepted one
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted during lookup");

   // A new result appears only after a get was accepted and passed its lookup and update
   a_rsp_from_get: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_cmd == OP_GET, 3))
      else $error("result without a matching get");
endmodule

bind lru_key_value_cache lkvc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_cmd        (req_chan.cmd),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_hit        (rsp_chan.hit),
   .rsp_read_value (rsp_chan.read_value)
);

[verif/lkvc_result_checker.sv]
// Result checker of the LRU key-value cache: tracks cache contents and compares get results.
module lkvc_result_checker import lkvc_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_hit,
   input  logic [VALUE_W-1:0]    rsp_read_value,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending_reads
);

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
   } lookup_result_type;

   // Shadow copy of the cache contents and the capacity register
   logic [KEY_W-1:0]   shadow_tag  [SLOTS];
   logic [VALUE_W-1:0] shadow_data [SLOTS];
   bit                 shadow_live [SLOTS];
   int unsigned        shadow_age  [SLOTS];
   int unsigned        shadow_held;
   logic [CAP_W-1:0]   shadow_capacity;

   lookup_result_type expected_reads[$];

   // Count a failure; tell the caller whether it is still worth printing
   function automatic bit note_failure();
      fail_count++;
      return fail_count <= 10;
   endfunction

   function automatic int unsigned usable_capacity();
      if (shadow_capacity == '0) return 1;
      if (shadow_capacity > SLOTS) return SLOTS;
      return shadow_capacity;
   endfunction

   function automatic int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_live[i] && shadow_tag[i] == k) return i;
      end
      return -1;
   endfunction

   // Make a slot most recent: every live entry younger than it ages by one
   function automatic void make_recent(int slot, int unsigned old_age);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_live[i] && i != slot && shadow_age[i] < old_age) shadow_age[i]++;
      end
      shadow_age[slot] = 0;
   endfunction

   // Apply one request to the shadow cache; queue the result of a get
   function automatic void cache_access(logic cmd, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
      int                slot;
      int                victim;
      int unsigned       oldest;
      lookup_result_type outcome;
      slot = find_slot(k);
      if (cmd == OP_GET) begin
         if (slot >= 0) begin
            outcome.hit        = 1'b1;
            outcome.read_value = shadow_data[slot];
            make_recent(slot, shadow_age[slot]);
         end else begin
            outcome.hit        = 1'b0;
            outcome.read_value = MISS_VALUE;
         end
         expected_reads.push_back(outcome);
      end else if (slot >= 0) begin
         shadow_data[slot] = v;
         make_recent(slot, shadow_age[slot]);
      end else if (shadow_held < usable_capacity()) begin
         // fill the lowest free slot, everything else ages
         slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_live[i] && slot < 0) slot = i;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_live[i]) shadow_age[i]++;
         end
         shadow_live[slot] = 1'b1;
         shadow_tag[slot]  = k;
         shadow_data[slot] = v;
         shadow_age[slot]  = 0;
         shadow_held++;
      end else begin
         // replace the least recent entry
         victim = -1;
         oldest = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_live[i] && (victim < 0 || shadow_age[i] > oldest)) begin
               victim = i;
               oldest = shadow_age[i];
            end
         end
         shadow_tag[victim]  = k;
         shadow_data[victim] = v;
         make_recent(victim, oldest);
      end
   endfunction

   always @(posedge clock) begin
      lookup_result_type seen;
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            shadow_tag[i]  = '0;
            shadow_data[i] = '0;
            shadow_live[i] = 1'b0;
            shadow_age[i]  = 0;
         end
         shadow_held     = 0;
         shadow_capacity = CAP_RESET;
         expected_reads.delete();
         fail_count      = 0;
      end else begin
         // Track register writes, check register reads
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == ADDR_CAPACITY) shadow_capacity = pwdata[CAP_W-1:0];
            end else if (paddr == ADDR_CAPACITY &&
                         prdata !== CSR_DATA_W'(shadow_capacity)) begin
               if (note_failure())
                  $display("capacity readback: expected %h, got %h",
                           CSR_DATA_W'(shadow_capacity), prdata);
            end
         end
         // Compare each result item with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            seen.hit        = rsp_hit;
            seen.read_value = rsp_read_value;
            if (expected_reads.size() == 0) begin
               if (note_failure())
                  $display("result with nothing expected: hit=%0b value=%h",
                           seen.hit, seen.read_value);
            end else begin
               want = expected_reads.pop_front();
               if (seen.hit !== want.hit || seen.read_value !== want.read_value) begin
                  if (note_failure())
                     $display("get result: expected hit=%0b value=%h, got hit=%0b value=%h",
                              want.hit, want.read_value, seen.hit, seen.read_value);
               end
            end
         end
         // Predict from each accepted request item
         if (req_valid && req_ready) cache_access(req_cmd, req_key, req_value);
      end
      pending_reads = expected_reads.size();
   end

endmodule

[verif/tb_lru_key_value_cache.sv]
// Testbench top of the LRU key-value cache: clock, reset, stimulus and verdict.
module tb_lru_key_value_cache;
   import lkvc_pkg::*;

   localparam int SLOTS     = 16;
   localparam int POOL_SIZE = 24;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending_reads;
   bit                    no_idle = 1'b0;

   lkvc_req_if req_bus ();
   lkvc_rsp_if rsp_bus ();

   lru_key_value_cache #(
      .MAX_ENTRIES (SLOTS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   lkvc_result_checker #(
      .SLOTS (SLOTS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_cmd        (req_bus.cmd),
      .req_key        (req_bus.key),
      .req_value      (req_bus.value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_hit        (rsp_bus.hit),
      .rsp_read_value (rsp_bus.read_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .fail_count     (fail_count),
      .pending_reads  (pending_reads)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= 18);
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("lru_key_value_cache regression: fail");
      $finish;
   end

   // Insert random idle cycles before the next request item
   task automatic idle_gap();
      while (!no_idle && $urandom_range(99) < 18) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_item(op_type op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      idle_gap();
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= op;
      req_bus.key   <= k;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold requests until every get has been answered, then let puts settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_reads != 0);
      repeat (8) @(posedge clock);
   endtask

   // One register transfer; back-to-back transfers skip the idle state
   task automatic csr_cycle(bit is_write, logic [CSR_DATA_W-1:0] word);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= ADDR_CAPACITY;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Write the capacity with random upper bits, then read it back
   task automatic program_capacity(logic [CAP_W-1:0] cap);
      logic [CSR_DATA_W-1:0] word;
      word             = $urandom();
      word[CAP_W-1:0]  = cap;
      csr_cycle(1'b1, word);
      csr_cycle(1'b0, '0);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      logic [CAP_W-1:0]   phase_caps [8];
      logic [KEY_W-1:0]   key_pool [POOL_SIZE];
      logic [KEY_W-1:0]   k;
      int unsigned        span;
      op_type             op;

      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.cmd    <= OP_GET;
      req_bus.key    <= '0;
      req_bus.value  <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Read the reset capacity
      csr_cycle(1'b0, '0);
      psel    <= 1'b0;
      penable <= 1'b0;

      // Empty cache, key and value extremes, overwrite
      send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_item(OP_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(OP_GET, 32'h8000_0000, 32'hdead_beef);
      send_item(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_GET, 32'hffff_ffff, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_0001, 32'h0000_0000);
      send_item(OP_PUT, 32'h0000_0000, 32'h1234_5678);
      send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);

      // Capacity lowered below the number of entries held
      drain();
      program_capacity(5'd2);
      send_item(OP_PUT, 32'h0000_0055, 32'haaaa_aaaa);
      send_item(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_0055, 32'h0000_0000);

      // Capacity zero behaves as one
      drain();
      program_capacity(5'd0);
      send_item(OP_PUT, 32'h0000_0007, 32'h0000_0007);
      send_item(OP_PUT, 32'h0000_0008, 32'h0000_0008);
      send_item(OP_GET, 32'h0000_0007, 32'h0000_0000);
      send_item(OP_GET, 32'h0000_0008, 32'h0000_0000);

      // Random phases over a range of capacities, one without idling
      phase_caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd4, 5'd17, 5'd2, 5'd9};
      foreach (phase_caps[p]) begin
         drain();
         program_capacity(phase_caps[p]);
         no_idle = (p == 2);
         foreach (key_pool[i]) key_pool[i] = $urandom();
         key_pool[0] = 32'h8000_0000;
         key_pool[1] = 32'h7fff_ffff;
         if (phase_caps[p] == '0) span = 1;
         else if (phase_caps[p] > SLOTS) span = SLOTS;
         else span = phase_caps[p];
         span = (span + 4 > POOL_SIZE) ? POOL_SIZE : span + 4;
         // Mostly keys from a small pool so hits, updates and evictions recur
         repeat (56) begin
            op = ($urandom_range(1) == 1) ? OP_PUT : OP_GET;
            if ($urandom_range(9) == 0) k = $urandom();
            else k = key_pool[$urandom_range(span - 1)];
            send_item(op, k, $urandom());
         end
      end
      no_idle = 1'b0;

      drain();
      if (fail_count == 0) begin
         $display("lru_key_value_cache regression: pass");
      end else begin
         $display("lru_key_value_cache regression: fail");
      end
      $finish;
   end

endmodule
